FILE: hdl/cse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Color sequence editor package
// Shared widths, operation and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = 11;
    localparam int POS_W    = 16;
    localparam int COLOR_W  = 3;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE_AT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE_CLR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REVERSE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STREAM,
        ST_INS_WR,
        ST_RV_RD_LO,
        ST_RV_RD_HI,
        ST_RV_WR_LO,
        ST_RV_WR_HI,
        ST_RD_REQ,
        ST_RD_DATA,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/color_sequence_editor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Color sequence editor core
// Edits an ordered sequence of color codes held in a RAM, one beat at a time.
// ----------------------------------------------------------------------------
// Insert and erase at a position shift the entries behind that point, erase of
// a color streams the whole sequence, and reverse swaps pairs one at a time
// through the single RAM port pair; the next beat is taken in the cycle after
// the result loads. Reset clears the entry count and out_valid, not the RAM.
module color_sequence_editor_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic [cse_pkg::MODE_W-1:0]     mode,
    input  wire logic [cse_pkg::COLOR_W-1:0]    color,
    input  wire logic [cse_pkg::POS_W-1:0]      position_a,
    input  wire logic [cse_pkg::POS_W-1:0]      position_b,
    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      logic [cse_pkg::COLOR_W-1:0]    read_color,
    output      logic [cse_pkg::CNT_W-1:0]      length,
    output      logic [cse_pkg::STATUS_W-1:0]   status
);

    import cse_pkg::*;

    state_t                state_reg, state_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [COLOR_W-1:0]    color_reg, color_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]      rd_left_reg, rd_left_next;
    logic                  inflight_reg, inflight_next;
    logic [CNT_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]     at_reg, at_next;
    logic [ADDR_W-1:0]     lo_reg, lo_next;
    logic [ADDR_W-1:0]     hi_reg, hi_next;
    logic [COLOR_W-1:0]    tmp_reg, tmp_next;
    logic [COLOR_W-1:0]    res_color_reg, res_color_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]    out_color_reg, out_color_next;
    logic [CNT_W-1:0]      out_length_reg, out_length_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COLOR_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [COLOR_W-1:0]    ram_rdata;

    logic                  accept;
    logic                  stream_end;
    logic                  out_load;
    logic                  step_down;
    logic [POS_W-1:0]      len_ext;
    logic [CNT_W-1:0]      ins_at;
    logic [CNT_W-1:0]      clamp_a;
    logic [CNT_W-1:0]      clamp_b;
    logic [CNT_W-1:0]      rv_lo;
    logic [CNT_W-1:0]      rv_hi;
    logic                  rd_in_range;

    function automatic logic [CNT_W-1:0] clamp_pos(input logic [POS_W-1:0] p,
                                                   input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] r;
        if (p == '0)
        begin
            r = CNT_W'(1);
        end
        else if (p > POS_W'(len))
        begin
            r = len;
        end
        else
        begin
            r = CNT_W'(p);
        end
        return r;
    endfunction

    cse_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept      = in_valid && in_ready;
    assign stream_end  = (rd_left_reg == '0) && !inflight_reg;
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign step_down   = (mode_reg == MODE_INSERT);
    assign len_ext     = POS_W'(count_reg);
    assign ins_at      = (position_a < len_ext) ? CNT_W'(position_a) : count_reg;
    assign clamp_a     = clamp_pos(position_a, count_reg);
    assign clamp_b     = clamp_pos(position_b, count_reg);
    assign rv_lo       = (clamp_a > clamp_b) ? clamp_b : clamp_a;
    assign rv_hi       = (clamp_a > clamp_b) ? clamp_a : clamp_b;
    assign rd_in_range = (position_a != '0) && (position_a <= len_ext);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_INSERT:
                        begin
                            state_next = (count_reg == DEPTH_CNT) ? ST_DONE : ST_STREAM;
                        end
                        MODE_ERASE_AT:
                        begin
                            state_next = (count_reg == '0) ? ST_DONE : ST_STREAM;
                        end
                        MODE_ERASE_CLR:
                        begin
                            state_next = ST_STREAM;
                        end
                        MODE_REVERSE:
                        begin
                            state_next = (count_reg == '0) ? ST_DONE : ST_RV_RD_LO;
                        end
                        MODE_READ:
                        begin
                            state_next = rd_in_range ? ST_RD_REQ : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_STREAM:
            begin
                if (stream_end)
                begin
                    state_next = step_down ? ST_INS_WR : ST_DONE;
                end
            end
            ST_INS_WR:   state_next = ST_DONE;
            ST_RV_RD_LO: state_next = (lo_reg < hi_reg) ? ST_RV_RD_HI : ST_DONE;
            ST_RV_RD_HI: state_next = ST_RV_WR_LO;
            ST_RV_WR_LO: state_next = ST_RV_WR_HI;
            ST_RV_WR_HI: state_next = ST_RV_RD_LO;
            ST_RD_REQ:   state_next = ST_RD_DATA;
            ST_RD_DATA:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = wr_ptr_reg[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = rd_addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_STREAM:
            begin
                if (inflight_reg)
                begin
                    ram_we = (mode_reg == MODE_ERASE_CLR) ? (ram_rdata != color_reg) : 1'b1;
                end
            end
            ST_INS_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = at_reg;
                ram_wdata = color_reg;
            end
            ST_RV_RD_LO:
            begin
                ram_raddr = lo_reg;
            end
            ST_RV_RD_HI:
            begin
                ram_raddr = hi_reg;
            end
            ST_RV_WR_LO:
            begin
                ram_we    = 1'b1;
                ram_waddr = lo_reg;
            end
            ST_RV_WR_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = tmp_reg;
            end
            ST_RD_REQ:
            begin
                ram_raddr = at_reg;
            end
            ST_RD_DATA, ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        mode_next       = mode_reg;
        color_next      = color_reg;
        count_next      = count_reg;
        rd_addr_next    = rd_addr_reg;
        rd_left_next    = rd_left_reg;
        inflight_next   = 1'b0;
        wr_ptr_next     = wr_ptr_reg;
        at_next         = at_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        tmp_next        = tmp_reg;
        res_color_next  = res_color_reg;
        res_status_next = res_status_reg;

        if (accept)
        begin
            mode_next       = mode;
            color_next      = color;
            res_color_next  = '0;
            res_status_next = STATUS_OK;
            case (mode)
                MODE_INSERT:
                begin
                    if (count_reg == DEPTH_CNT)
                    begin
                        res_status_next = STATUS_FULL;
                    end
                    at_next      = ins_at[ADDR_W-1:0];
                    rd_left_next = count_reg - ins_at;
                    rd_addr_next = ADDR_W'(count_reg - CNT_W'(1));
                    wr_ptr_next  = count_reg;
                end
                MODE_ERASE_AT:
                begin
                    rd_left_next = count_reg - clamp_a;
                    rd_addr_next = clamp_a[ADDR_W-1:0];
                    wr_ptr_next  = clamp_a - CNT_W'(1);
                end
                MODE_ERASE_CLR:
                begin
                    rd_left_next = count_reg;
                    rd_addr_next = '0;
                    wr_ptr_next  = '0;
                end
                MODE_REVERSE:
                begin
                    lo_next = ADDR_W'(rv_lo - CNT_W'(1));
                    hi_next = ADDR_W'(rv_hi - CNT_W'(1));
                end
                MODE_READ:
                begin
                    at_next = ADDR_W'(position_a - POS_W'(1));
                    if (!rd_in_range)
                    begin
                        res_status_next = STATUS_BAD_POS;
                    end
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_STREAM:
            begin
                if (rd_left_reg != '0)
                begin
                    inflight_next = 1'b1;
                    rd_left_next  = rd_left_reg - CNT_W'(1);
                    rd_addr_next  = step_down ? (rd_addr_reg - ADDR_W'(1))
                                              : (rd_addr_reg + ADDR_W'(1));
                end
                if (ram_we)
                begin
                    wr_ptr_next = step_down ? (wr_ptr_reg - CNT_W'(1))
                                            : (wr_ptr_reg + CNT_W'(1));
                end
                if (stream_end)
                begin
                    if (mode_reg == MODE_ERASE_AT)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    else if (mode_reg == MODE_ERASE_CLR)
                    begin
                        count_next = wr_ptr_reg;
                    end
                end
            end
            ST_INS_WR:
            begin
                count_next = count_reg + CNT_W'(1);
            end
            ST_RV_RD_HI:
            begin
                tmp_next = ram_rdata;
            end
            ST_RV_WR_HI:
            begin
                lo_next = lo_reg + ADDR_W'(1);
                hi_next = hi_reg - ADDR_W'(1);
            end
            ST_RD_DATA:
            begin
                res_color_next = ram_rdata;
            end
            default:
            begin
            end
        endcase

        out_valid_next  = out_valid_reg && !out_ready;
        out_color_next  = out_color_reg;
        out_length_next = out_length_reg;
        out_status_next = out_status_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_color_next  = res_color_reg;
            out_length_next = count_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            inflight_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            inflight_reg  <= inflight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        color_reg      <= color_next;
        rd_addr_reg    <= rd_addr_next;
        rd_left_reg    <= rd_left_next;
        wr_ptr_reg     <= wr_ptr_next;
        at_reg         <= at_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        tmp_reg        <= tmp_next;
        res_color_reg  <= res_color_next;
        res_status_reg <= res_status_next;
        out_color_reg  <= out_color_next;
        out_length_reg <= out_length_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_color = out_color_reg;
    assign length     = out_length_reg;
    assign status     = out_status_reg;

    // The entry count never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above depth");

    // A swap is only written while the bounds are still apart.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RV_WR_LO |-> lo_reg < hi_reg)
        else $error("reverse swap with crossed bounds");

    // A dropped insert is reported only with a full store.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_FULL) |-> length == DEPTH_CNT)
        else $error("full status with spare room");

    // A nonzero color is returned only by a successful read.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_color != '0) |-> status == STATUS_OK)
        else $error("read color with error status");

endmodule
`default_nettype wire

FILE: hdl/cse_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: tb/color_sequence_editor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color sequence editor checker
// Watches the input and result channels of the editor, keeps its own copy of
// the color sequence, predicts the result of every accepted input beat and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module color_sequence_editor_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [cse_pkg::MODE_W-1:0]      mode,
    input  logic [cse_pkg::COLOR_W-1:0]     color,
    input  logic [cse_pkg::POS_W-1:0]       position_a,
    input  logic [cse_pkg::POS_W-1:0]       position_b,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [cse_pkg::COLOR_W-1:0]     read_color,
    input  logic [cse_pkg::CNT_W-1:0]       length,
    input  logic [cse_pkg::STATUS_W-1:0]    status,
    output int                              errors,
    output int                              pending
);

    import cse_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0]  read_color;
        logic [CNT_W-1:0]    length;
        logic [STATUS_W-1:0] status;
    } edit_result_t;

    logic [COLOR_W-1:0] seq_mem [DEPTH];
    int                 seq_len;
    edit_result_t       expected_results [$];

    function automatic int clamp_position(input logic [POS_W-1:0] p);
        int v;
        v = int'(p);
        if (v < 1)
        begin
            v = 1;
        end
        if (v > seq_len)
        begin
            v = seq_len;
        end
        return v;
    endfunction

    function automatic edit_result_t apply_edit(
        input logic [MODE_W-1:0]  op,
        input logic [COLOR_W-1:0] c,
        input logic [POS_W-1:0]   pa,
        input logic [POS_W-1:0]   pb
    );
        edit_result_t       r;
        logic [COLOR_W-1:0] held;
        int                 at;
        int                 k;
        int                 lo;
        int                 hi;
        int                 w;
        r.read_color = '0;
        r.length     = '0;
        r.status     = STATUS_OK;
        case (op)
            MODE_INSERT:
            begin
                if (seq_len >= DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    at = (int'(pa) < seq_len) ? int'(pa) : seq_len;
                    for (k = seq_len; k > at; k--)
                    begin
                        seq_mem[k] = seq_mem[k - 1];
                    end
                    seq_mem[at] = c;
                    seq_len++;
                end
            end
            MODE_ERASE_AT:
            begin
                if (seq_len > 0)
                begin
                    for (k = clamp_position(pa) - 1; k + 1 < seq_len; k++)
                    begin
                        seq_mem[k] = seq_mem[k + 1];
                    end
                    seq_len--;
                end
            end
            MODE_ERASE_CLR:
            begin
                w = 0;
                for (k = 0; k < seq_len; k++)
                begin
                    if (seq_mem[k] !== c)
                    begin
                        seq_mem[w] = seq_mem[k];
                        w++;
                    end
                end
                seq_len = w;
            end
            MODE_REVERSE:
            begin
                if (seq_len > 0)
                begin
                    lo = clamp_position(pa) - 1;
                    hi = clamp_position(pb) - 1;
                    if (lo > hi)
                    begin
                        k  = lo;
                        lo = hi;
                        hi = k;
                    end
                    while (lo < hi)
                    begin
                        held        = seq_mem[lo];
                        seq_mem[lo] = seq_mem[hi];
                        seq_mem[hi] = held;
                        lo++;
                        hi--;
                    end
                end
            end
            MODE_READ:
            begin
                if (int'(pa) >= 1 && int'(pa) <= seq_len)
                begin
                    r.read_color = seq_mem[int'(pa) - 1];
                end
                else
                begin
                    r.status = STATUS_BAD_POS;
                end
            end
            default:
            begin
            end
        endcase
        r.length = CNT_W'(seq_len);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        edit_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            seq_len = 0;
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, actual %0d/%0d/%0d",
                             $time, read_color, length, status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_color", want.read_color, read_color);
                    check_field("length", want.length, length);
                    check_field("status", want.status, status);
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(apply_edit(mode, color, position_a, position_b));
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: tb/color_sequence_editor_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color sequence editor testbench
// Drives directed and random edit beats into the editor core, with random
// gaps on the input side and random stalls on the result side, and reports
// the verdict from the checker's count.
// ----------------------------------------------------------------------------
module color_sequence_editor_core_tb;
    import cse_pkg::*;

    localparam int COLOR_CODES   = 6;
    localparam int RANDOM_BEATS  = 536;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int DRAIN_CYCLES  = 16;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [MODE_W-1:0]   mode       = '0;
    logic [COLOR_W-1:0]  color      = '0;
    logic [POS_W-1:0]    position_a = '0;
    logic [POS_W-1:0]    position_b = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [COLOR_W-1:0]  read_color;
    logic [CNT_W-1:0]    length;
    logic [STATUS_W-1:0] status;

    int errors;
    int pending;
    int seen_len   = 0;
    int beat_count = 0;
    int cycle_count = 0;
    bit calm       = 1'b0;

    color_sequence_editor_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .color      (color),
        .position_a (position_a),
        .position_b (position_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_color (read_color),
        .length     (length),
        .status     (status)
    );

    color_sequence_editor_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .color      (color),
        .position_a (position_a),
        .position_b (position_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_color (read_color),
        .length     (length),
        .status     (status),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_len = int'(length);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        if ($urandom_range(0, 99) < 8)
        begin
            return COLOR_W'($urandom_range(COLOR_CODES, 2**COLOR_W - 1));
        end
        return COLOR_W'($urandom_range(0, COLOR_CODES - 1));
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return '0;
        end
        if (r < 22)
        begin
            return POS_W'($urandom_range(0, 2**POS_W - 1));
        end
        return POS_W'($urandom_range(0, len + 2));
    endfunction

    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
            @(posedge clk);
        end
    end

    task automatic send_beat(input logic [MODE_W-1:0] m, input logic [COLOR_W-1:0] c,
                             input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        color      <= c;
        position_a <= a;
        position_b <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        beat_count++;
        if (beat_count % 48 == 0)
        begin
            calm = ($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic settle();
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    initial
    begin
        int                 r;
        int                 ins_weight;
        logic [MODE_W-1:0]  m;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(MODE_READ, 3'd0, 16'd1, 16'd0);
        send_beat(MODE_ERASE_AT, 3'd0, 16'd0, 16'd0);
        send_beat(MODE_REVERSE, 3'd0, 16'd0, 16'd0);
        send_beat(MODE_ERASE_CLR, 3'd3, 16'd0, 16'd0);
        send_beat(MODE_INSERT, 3'd0, 16'd0, 16'hFFFF);
        send_beat(MODE_INSERT, 3'd5, 16'hFFFF, 16'd0);
        send_beat(MODE_INSERT, 3'd7, 16'd1, 16'd0);
        send_beat(MODE_INSERT, 3'd6, 16'd0, 16'd0);
        send_beat(MODE_INSERT, 3'd2, 16'd2, 16'd0);
        send_beat(MODE_READ, 3'd0, 16'd0, 16'd0);
        send_beat(MODE_READ, 3'd0, 16'hFFFF, 16'd0);
        send_beat(MODE_READ, 3'd0, 16'd5, 16'd0);
        send_beat(MODE_REVERSE, 3'd0, 16'hFFFF, 16'd0);
        send_beat(MODE_REVERSE, 3'd0, 16'd3, 16'd3);
        send_beat(MODE_READ, 3'd0, 16'd1, 16'd0);
        send_beat(MODE_ERASE_CLR, 3'd7, 16'd0, 16'd0);
        send_beat(MODE_ERASE_AT, 3'd0, 16'd0, 16'd0);
        send_beat(MODE_ERASE_AT, 3'd0, 16'hFFFF, 16'd0);
        for (int k = MODE_READ + 1; k < 2**MODE_W; k++)
        begin
            send_beat(MODE_W'(k), pick_color(), pick_position(4), 16'hFFFF);
        end
        send_beat(MODE_REVERSE, 3'd0, 16'd2, 16'd1);
        send_beat(MODE_READ, 3'd0, 16'd2, 16'd0);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            ins_weight = (seen_len < 8) ? 50 : (seen_len > 48) ? 10 : 30;
            if ($urandom_range(0, 99) < ins_weight)
            begin
                m = MODE_INSERT;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 22)
                begin
                    m = MODE_ERASE_AT;
                end
                else if (r < 32)
                begin
                    m = MODE_ERASE_CLR;
                end
                else if (r < 55)
                begin
                    m = MODE_REVERSE;
                end
                else if (r < 95)
                begin
                    m = MODE_READ;
                end
                else
                begin
                    m = MODE_W'($urandom_range(MODE_READ + 1, 2**MODE_W - 1));
                end
            end
            send_beat(m, pick_color(), pick_position(seen_len), pick_position(seen_len));
        end

        send_beat(MODE_INSERT, pick_color(), 16'd0, 16'd0);
        send_beat(MODE_INSERT, pick_color(), 16'hFFFF, 16'd0);
        send_beat(MODE_READ, 3'd0, POS_W'(DEPTH), 16'd0);
        send_beat(MODE_READ, 3'd0, POS_W'(DEPTH + 1), 16'd0);
        send_beat(MODE_READ, 3'd0, 16'd1, 16'd0);
        send_beat(MODE_REVERSE, 3'd0, 16'd1, 16'hFFFF);
        send_beat(MODE_REVERSE, 3'd0, 16'd700, 16'd300);
        send_beat(MODE_READ, 3'd0, 16'd500, 16'd0);
        send_beat(MODE_ERASE_AT, 3'd0, 16'hFFFF, 16'd0);
        send_beat(MODE_INSERT, pick_color(), 16'd0, 16'd0);
        send_beat(MODE_INSERT, pick_color(), 16'd512, 16'd0);
        send_beat(MODE_READ, 3'd0, 16'd1, 16'd0);
        for (int k = 0; k < 2**COLOR_W; k++)
        begin
            send_beat(MODE_ERASE_CLR, COLOR_W'(k), pick_position(DEPTH), 16'd0);
        end
        send_beat(MODE_READ, 3'd0, 16'd1, 16'd0);

        in_valid <= 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
